[design/psp_pkg.sv]
// Shared types and codes for the polygon stream parser.
// No dependencies; imported by every module of the block.
package psp_pkg;

  typedef enum logic [2:0] {
    KIND_PALETTE    = 3'd0,
    KIND_VERTEX     = 3'd1,
    KIND_END_FRAME  = 3'd2,
    KIND_NEXT_BLOCK = 3'd3,
    KIND_END_STREAM = 3'd4
  } kind_t;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PALETTE_FLAG_MASK = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INDEXED_FLAG_MASK = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_FRAME_CODE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEXT_BLOCK_CODE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_STREAM_CODE   = 3'd4;

  // Result word as it leaves the parser; x/y may still come from the table.
  typedef struct packed {
    kind_t      kind;
    logic [3:0] pal_index;
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
    logic [7:0] vert_x;
    logic [7:0] vert_y;
    logic [3:0] poly_colour;
    logic [3:0] poly_size;
    logic       last_vertex;
    logic       from_table;
    logic       table_hit;
  } res_desc_t;

  // Vertex table access issued by the parser.
  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [15:0] wr_data;
    logic        rd_en;
    logic [7:0]  rd_idx;
  } vtab_req_t;

endpackage

[design/psp_vtab.sv]
// Vertex table: synchronous single-write, single-read memory, read data registered.
// Depends on psp_pkg for the request struct.
module psp_vtab #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  psp_pkg::vtab_req_t req,
  output logic [15:0]        rd_data
);
  import psp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_idx[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/psp_parser.sv]
// Byte parser: frame/palette/table/polygon sequencing, config registers, table accesses.
// Depends on psp_pkg for result and table request types.
module psp_parser #(
  parameter int BLOCK_BYTES_LOG2   = 16,
  parameter int VERTEX_TABLE_DEPTH = 256,
  parameter int ADDRESS_BITS       = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [psp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [psp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                accept,
  input  logic                                action,
  input  logic [7:0]                          data_byte,
  output logic                                emit,
  output psp_pkg::res_desc_t                  desc,
  output psp_pkg::vtab_req_t                  vreq
);
  import psp_pkg::*;

  localparam int AB = ADDRESS_BITS;
  localparam int BL = BLOCK_BYTES_LOG2;

  typedef enum logic [3:0] {
    PH_FLAGS   = 4'd0,
    PH_MASK_HI = 4'd1,
    PH_MASK_LO = 4'd2,
    PH_COL_HI  = 4'd3,
    PH_COL_LO  = 4'd4,
    PH_TCOUNT  = 4'd5,
    PH_TX      = 4'd6,
    PH_TY      = 4'd7,
    PH_HEADER  = 4'd8,
    PH_VIDX    = 4'd9,
    PH_VX      = 4'd10,
    PH_VY      = 4'd11,
    PH_SKIP    = 4'd12
  } phase_t;

  // highest set bit, with a found flag on top
  function automatic logic [4:0] top_bit(input logic [15:0] m);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (m[i]) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

  logic [7:0]    pal_mask_r, idx_mask_r, end_frame_r, next_block_r, end_stream_r;
  phase_t        phase_r, phase_nxt;
  logic [AB-1:0] addr_r, addr_nxt, addr_inc;
  logic [AB-1:0] skip_r, skip_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [15:0]   pmask_r, pmask_nxt;
  logic [3:0]    pbit_r, pbit_nxt;
  logic [7:0]    high_r, high_nxt;
  logic [7:0]    tcount_r, tcount_nxt;
  logic [7:0]    tpos_r, tpos_nxt;
  logic [3:0]    remain_r, remain_nxt;
  logic [3:0]    total_r, total_nxt;
  logic [3:0]    colour_r, colour_nxt;
  logic [7:0]    pend_x_r, pend_x_nxt;
  logic          ended_r, ended_nxt;

  logic [AB-BL-1:0] blk_next;
  logic             proceed;
  phase_t           cur;
  logic             ix_cur, ix_b;
  logic [4:0]       tb;
  logic [15:0]      mask_tmp;
  logic [3:0]       remain_dec;
  logic [7:0]       tpos_inc;
  logic             b_in_table, tpos_in_table;

  assign addr_inc      = addr_r + AB'(1);
  assign blk_next      = addr_inc[AB-1:BL] + (AB-BL)'(1);
  assign ix_cur        = |(flags_r & idx_mask_r);
  assign ix_b          = |(data_byte & idx_mask_r);
  assign remain_dec    = remain_r - 4'd1;
  assign tpos_inc      = tpos_r + 8'd1;
  assign b_in_table    = {1'b0, data_byte} < 9'(VERTEX_TABLE_DEPTH);
  assign tpos_in_table = {1'b0, tpos_r} < 9'(VERTEX_TABLE_DEPTH);
  assign proceed       = !ended_r && !(phase_r == PH_SKIP && addr_r != skip_r);
  assign cur           = (phase_r == PH_SKIP) ? PH_FLAGS : phase_r;

  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    skip_nxt   = skip_r;
    flags_nxt  = flags_r;
    pmask_nxt  = pmask_r;
    pbit_nxt   = pbit_r;
    high_nxt   = high_r;
    tcount_nxt = tcount_r;
    tpos_nxt   = tpos_r;
    remain_nxt = remain_r;
    total_nxt  = total_r;
    colour_nxt = colour_r;
    pend_x_nxt = pend_x_r;
    ended_nxt  = ended_r;
    emit       = 1'b0;
    desc       = '0;
    vreq       = '0;
    mask_tmp   = '0;
    tb         = '0;

    if (accept) begin
      if (action) begin
        addr_nxt  = '0;
        ended_nxt = 1'b0;
        phase_nxt = PH_FLAGS;
      end else begin
        addr_nxt = addr_inc;
        if (proceed) begin
          case (cur)
            PH_FLAGS: begin
              flags_nxt = data_byte;
              if (|(data_byte & pal_mask_r)) begin
                phase_nxt = PH_MASK_HI;
              end else begin
                phase_nxt = ix_b ? PH_TCOUNT : PH_HEADER;
              end
            end
            PH_MASK_HI: begin
              high_nxt  = data_byte;
              phase_nxt = PH_MASK_LO;
            end
            PH_MASK_LO: begin
              mask_tmp  = {high_r, data_byte};
              pmask_nxt = mask_tmp;
              tb        = top_bit(mask_tmp);
              if (tb[4]) begin
                pbit_nxt  = tb[3:0];
                phase_nxt = PH_COL_HI;
              end else begin
                phase_nxt = ix_cur ? PH_TCOUNT : PH_HEADER;
              end
            end
            PH_COL_HI: begin
              high_nxt  = data_byte;
              phase_nxt = PH_COL_LO;
            end
            PH_COL_LO: begin
              emit           = 1'b1;
              desc.kind      = KIND_PALETTE;
              desc.pal_index = ~pbit_r;
              desc.red       = {high_r[2:0], 1'b0};
              desc.green     = {data_byte[6:4], 1'b0};
              desc.blue      = {data_byte[2:0], 1'b0};
              mask_tmp       = pmask_r & ~(16'd1 << pbit_r);
              pmask_nxt      = mask_tmp;
              tb             = top_bit(mask_tmp);
              if (tb[4]) begin
                pbit_nxt  = tb[3:0];
                phase_nxt = PH_COL_HI;
              end else begin
                phase_nxt = ix_cur ? PH_TCOUNT : PH_HEADER;
              end
            end
            PH_TCOUNT: begin
              tcount_nxt = data_byte;
              tpos_nxt   = 8'd0;
              phase_nxt  = (data_byte == 8'd0) ? PH_HEADER : PH_TX;
            end
            PH_TX: begin
              pend_x_nxt = data_byte;
              phase_nxt  = PH_TY;
            end
            PH_TY: begin
              vreq.wr_en   = tpos_in_table;
              vreq.wr_idx  = tpos_r;
              vreq.wr_data = {pend_x_r, data_byte};
              tpos_nxt     = tpos_inc;
              phase_nxt    = (tpos_inc == tcount_r) ? PH_HEADER : PH_TX;
            end
            PH_HEADER: begin
              if (data_byte == end_frame_r) begin
                emit      = 1'b1;
                desc.kind = KIND_END_FRAME;
                phase_nxt = PH_FLAGS;
              end else if (data_byte == next_block_r) begin
                emit      = 1'b1;
                desc.kind = KIND_NEXT_BLOCK;
                skip_nxt  = {blk_next, {BL{1'b0}}};
                phase_nxt = PH_SKIP;
              end else if (data_byte == end_stream_r) begin
                emit      = 1'b1;
                desc.kind = KIND_END_STREAM;
                ended_nxt = 1'b1;
                phase_nxt = PH_FLAGS;
              end else begin
                total_nxt  = data_byte[3:0];
                colour_nxt = data_byte[7:4];
                remain_nxt = data_byte[3:0];
                if (data_byte[3:0] == 4'd0) begin
                  phase_nxt = PH_HEADER;
                end else begin
                  phase_nxt = ix_cur ? PH_VIDX : PH_VX;
                end
              end
            end
            PH_VIDX, PH_VY: begin
              emit             = 1'b1;
              desc.kind        = KIND_VERTEX;
              desc.poly_colour = colour_r;
              desc.poly_size   = total_r;
              desc.last_vertex = (remain_r == 4'd1);
              if (cur == PH_VIDX) begin
                // coordinates come from the registered table read, available in the following cycle
                desc.from_table = 1'b1;
                desc.table_hit  = b_in_table;
                vreq.rd_en      = 1'b1;
                vreq.rd_idx     = data_byte;
              end else begin
                desc.vert_x = pend_x_r;
                desc.vert_y = data_byte;
              end
              remain_nxt = remain_dec;
              if (remain_dec == 4'd0) begin
                phase_nxt = PH_HEADER;
              end else begin
                phase_nxt = ix_cur ? PH_VIDX : PH_VX;
              end
            end
            PH_VX: begin
              pend_x_nxt = data_byte;
              phase_nxt  = PH_VY;
            end
            default: begin
              phase_nxt = PH_FLAGS;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_mask_r   <= 8'd2;
      idx_mask_r   <= 8'd4;
      end_frame_r  <= 8'd255;
      next_block_r <= 8'd254;
      end_stream_r <= 8'd253;
      phase_r      <= PH_FLAGS;
      addr_r       <= '0;
      skip_r       <= '0;
      flags_r      <= '0;
      pmask_r      <= '0;
      pbit_r       <= 4'd15;
      high_r       <= '0;
      tcount_r     <= '0;
      tpos_r       <= '0;
      remain_r     <= '0;
      total_r      <= '0;
      colour_r     <= '0;
      pend_x_r     <= '0;
      ended_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PALETTE_FLAG_MASK: pal_mask_r   <= cfg_data;
          CFG_INDEXED_FLAG_MASK: idx_mask_r   <= cfg_data;
          CFG_END_FRAME_CODE:    end_frame_r  <= cfg_data;
          CFG_NEXT_BLOCK_CODE:   next_block_r <= cfg_data;
          CFG_END_STREAM_CODE:   end_stream_r <= cfg_data;
          default: ;
        endcase
      end
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      skip_r   <= skip_nxt;
      flags_r  <= flags_nxt;
      pmask_r  <= pmask_nxt;
      pbit_r   <= pbit_nxt;
      high_r   <= high_nxt;
      tcount_r <= tcount_nxt;
      tpos_r   <= tpos_nxt;
      remain_r <= remain_nxt;
      total_r  <= total_nxt;
      colour_r <= colour_nxt;
      pend_x_r <= pend_x_nxt;
      ended_r  <= ended_nxt;
    end
  end

endmodule

[design/psp_out.sv]
// Result pipeline: table-read stage then output register, with backpressure to the input.
// Depends on psp_pkg for the result descriptor.
module psp_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  psp_pkg::res_desc_t  desc_in,
  input  logic [15:0]         rd_data,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          kind,
  output logic [3:0]          pal_index,
  output logic [3:0]          red,
  output logic [3:0]          green,
  output logic [3:0]          blue,
  output logic [7:0]          vert_x,
  output logic [7:0]          vert_y,
  output logic [3:0]          poly_colour,
  output logic [3:0]          poly_size,
  output logic                last_vertex
);
  import psp_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  res_desc_t s1_r;
  logic      out_valid_r, out_valid_nxt;
  res_desc_t out_r, merged;
  logic      s1_go;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // table data is held by the memory until the next read, which cannot
  // be issued while this word waits here
  always_comb begin
    merged = s1_r;
    if (s1_r.from_table) begin
      merged.vert_x = s1_r.table_hit ? rd_data[15:8] : 8'd0;
      merged.vert_y = s1_r.table_hit ? rd_data[7:0] : 8'd0;
    end
    s1_valid_nxt  = load ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_go ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= desc_in;
    end
    if (s1_go) begin
      out_r <= merged;
    end
  end

  assign out_valid   = out_valid_r;
  assign kind        = out_r.kind;
  assign pal_index   = out_r.pal_index;
  assign red         = out_r.red;
  assign green       = out_r.green;
  assign blue        = out_r.blue;
  assign vert_x      = out_r.vert_x;
  assign vert_y      = out_r.vert_y;
  assign poly_colour = out_r.poly_colour;
  assign poly_size   = out_r.poly_size;
  assign last_vertex = out_r.last_vertex;

endmodule

[design/polygon_stream_parser_unit.sv]
// Top level of the polygon stream parser: parser, vertex table memory, result pipeline.
// Depends on psp_pkg, psp_parser, psp_vtab and psp_out.
//
// Takes one stream word per clock, back to back, while in_ready is high, and emits at
// most one result word per input word; out_ready low holds the result pipeline. An
// accepted result is registered in the table-read stage, where table read data is
// merged in, then in the output register. The table has a write and a read port and
// needs no clearing pass after reset; entries read before being written give undefined
// x/y. Configuration writes take effect on the next clock and should be made while idle.
module polygon_stream_parser_unit #(
  parameter int BLOCK_BYTES_LOG2   = 16,
  parameter int VERTEX_TABLE_DEPTH = 256,
  parameter int ADDRESS_BITS       = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [psp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [psp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_kind,
  output logic [3:0]                        out_pal_index,
  output logic [3:0]                        out_red,
  output logic [3:0]                        out_green,
  output logic [3:0]                        out_blue,
  output logic [7:0]                        out_vert_x,
  output logic [7:0]                        out_vert_y,
  output logic [3:0]                        out_poly_colour,
  output logic [3:0]                        out_poly_size,
  output logic                              out_last_vertex
);
  import psp_pkg::*;

  logic        accept;
  logic        emit;
  res_desc_t   desc;
  vtab_req_t   vreq;
  logic [15:0] rd_data;

  assign accept = in_valid && in_ready;

  psp_parser #(
    .BLOCK_BYTES_LOG2  (BLOCK_BYTES_LOG2),
    .VERTEX_TABLE_DEPTH(VERTEX_TABLE_DEPTH),
    .ADDRESS_BITS      (ADDRESS_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .action   (in_action),
    .data_byte(in_data_byte),
    .emit     (emit),
    .desc     (desc),
    .vreq     (vreq)
  );

  psp_vtab #(
    .DEPTH(VERTEX_TABLE_DEPTH)
  ) u_vtab (
    .clk    (clk),
    .req    (vreq),
    .rd_data(rd_data)
  );

  psp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && emit),
    .desc_in    (desc),
    .rd_data    (rd_data),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (out_kind),
    .pal_index  (out_pal_index),
    .red        (out_red),
    .green      (out_green),
    .blue       (out_blue),
    .vert_x     (out_vert_x),
    .vert_y     (out_vert_y),
    .poly_colour(out_poly_colour),
    .poly_size  (out_poly_size),
    .last_vertex(out_last_vertex)
  );

endmodule
